/* rtl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* rtl/sfmm_pkg.sv */
`default_nettype none
package sfmm_pkg;
  localparam int MaxDim   = 64;
  localparam int IdxW     = $clog2(MaxDim);
  localparam int AddrW    = 2 * IdxW;
  localparam int Depth    = MaxDim * MaxDim;
  localparam int CfgW     = 7;
  localparam int KW       = $clog2(MaxDim + 1);
  localparam logic [31:0] DefaultNan = 32'hFFC00000;
  localparam logic [31:0] QnanBit    = 32'h00400000;

  typedef enum logic [1:0] {
    OpLoadLeft  = 2'd0,
    OpLoadRight = 2'd1,
    OpQuery     = 2'd2,
    OpNone      = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegLeftRows     = 2'd0,
    RegInnerLength  = 2'd1,
    RegRightColumns = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    StIdle, StRead, StMul, StAdd, StOut
  } state_e;

  function automatic logic is_nan(input logic [31:0] b);
    return b[30:23] == 8'hFF && b[22:0] != 23'd0;
  endfunction

  // round-to-nearest-even packing of a normalised magnitude
  // m: 50-bit magnitude, hidden bit at 49 when e>=1, round and sticky below bit 26
  // e: biased exponent
  function automatic logic [31:0] pack(input logic s, input logic signed [11:0] e,
                                       input logic [49:0] m);
    logic [49:0] mm;
    logic signed [11:0] ee;
    logic [24:0] r;
    logic lsb, g, st;
    int sh;
    mm = m;
    ee = e;
    if (ee < 1) begin
      sh = 1 - int'(ee);
      if (sh > 50) sh = 50;
      mm = (m >> sh) | {49'd0, |(m & ((50'd1 << sh) - 50'd1))};
      ee = 12'sd0;
    end
    lsb = mm[26];
    g   = mm[25];
    st  = |mm[24:0];
    r = {1'b0, mm[49:26]} + {24'd0, g & (st | lsb)};
    if (r[24]) begin
      ee = ee + 12'sd1;
      r = r >> 1;
    end else if (ee == 0 && r[23]) begin
      ee = 12'sd1;
    end
    if (ee >= 255) return {s, 8'hFF, 23'd0};
    return {s, ee[7:0], r[22:0]};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    logic [23:0] ma, mb;
    logic signed [11:0] ea, eb, e;
    logic [47:0] p;
    logic [49:0] m;
    int lz;
    if (is_nan(a)) return a | QnanBit;
    if (is_nan(b)) return b | QnanBit;
    s = a[31] ^ b[31];
    if ((a[30:23] == 8'hFF && b[30:0] == 31'd0) || (b[30:23] == 8'hFF && a[30:0] == 31'd0))
      return DefaultNan;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {s, 8'hFF, 23'd0};
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {s, 31'd0};
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    ea = (a[30:23] == 0) ? 12'sd1 : $signed({4'd0, a[30:23]});
    eb = (b[30:23] == 0) ? 12'sd1 : $signed({4'd0, b[30:23]});
    p = ma * mb;
    lz = 0;
    for (int i = 47; i >= 0; i--) if (p[i]) begin lz = 47 - i; break; end
    m = {p << lz, 2'b0};
    e = ea + eb - 12'sd126 - 12'(lz);
    return pack(s, e, m);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x, y;
    logic [7:0] ex, ey;
    logic [52:0] mx, my, d;
    logic [53:0] sm;
    logic signed [11:0] e;
    logic [49:0] m;
    int sh, lz;
    if (is_nan(a)) return a | QnanBit;
    if (is_nan(b)) return b | QnanBit;
    if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
      return (a[31] != b[31]) ? DefaultNan : a;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] >= b[30:0]) begin x = a; y = b; end else begin x = b; y = a; end
    ex = (x[30:23] == 0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 0) ? 8'd1 : y[30:23];
    mx = {1'b0, x[30:23] != 0, x[22:0], 28'd0};
    my = {1'b0, y[30:23] != 0, y[22:0], 28'd0};
    sh = int'(ex) - int'(ey);
    if (sh > 52) d = {52'd0, |my};
    else d = (my >> sh) | {52'd0, |(my & ((53'd1 << sh) - 53'd1))};
    if (x[31] == y[31]) sm = {1'b0, mx} + {1'b0, d};
    else sm = {1'b0, mx} - {1'b0, d};
    if (sm == 0) return 32'd0;
    lz = 0;
    for (int i = 53; i >= 0; i--) if (sm[i]) begin lz = 53 - i; break; end
    // hidden position in sm is 51 -> value exponent ex
    e = $signed({4'd0, ex}) + 12'sd2 - 12'(lz);
    sm = sm << lz;
    m = sm[53:4] | {49'd0, |sm[3:0]};
    return pack(x[31], e, m);
  endfunction
endpackage
`default_nettype wire

/* rtl/sfmm_if.sv */
`default_nettype none
interface sfmm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [5:0]  row_index;
  logic [5:0]  column_index;
  logic [31:0] element_bits;
  modport source (output valid, op, row_index, column_index, element_bits, input ready);
  modport sink   (input valid, op, row_index, column_index, element_bits, output ready);
endinterface

interface sfmm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic        index_error;
  modport source (output valid, result_bits, index_error, input ready);
  modport sink   (input valid, result_bits, index_error, output ready);
endinterface

interface sfmm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [6:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/sfmm_ram.sv */
`default_nettype none
module sfmm_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/strict_f32_matrix_multiply.sv */
// flow: a query steps through the read, multiply and add stages of the loop once per k, with K
//   clipped to 64, before its word is offered; an out-of-range query word in the cycle after acceptance
// throughput: one load per cycle while no query is in progress; one query at a time, and no new
//   word is taken until the result word has been taken
// reset: rst_ni clears the size registers and control; the stores are not cleared
`default_nettype none
`include "assert_macros.svh"
module strict_f32_matrix_multiply (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sfmm_cfg_if.sink    cfg_i,
  sfmm_in_if.sink     in_i,
  sfmm_out_if.source  out_o
);
  // size registers
  logic [sfmm_pkg::CfgW-1:0] rows_q, inner_q, cols_q;
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0; inner_q <= '0; cols_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        sfmm_pkg::RegLeftRows:     rows_q  <= cfg_i.data;
        sfmm_pkg::RegInnerLength:  inner_q <= cfg_i.data;
        sfmm_pkg::RegRightColumns: cols_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  sfmm_pkg::state_e state_q, state_d;
  logic [sfmm_pkg::IdxW-1:0] row_q, col_q;
  logic [sfmm_pkg::KW-1:0]   k_q, k_d, kmax_q, kmax_d;
  logic [31:0] sum_q, sum_d, prod_q, prod_d, res_q, res_d;
  logic err_q, err_d;
  logic in_acc, out_vld;

  // stores: left at row*MaxDim+k, right at k*MaxDim+col
  logic [sfmm_pkg::AddrW-1:0] waddr, laddr, raddr;
  logic [31:0] ldata, rdata;
  logic lwe, rwe;
  logic [sfmm_pkg::IdxW-1:0] kidx;
  assign kidx  = k_q[sfmm_pkg::IdxW-1:0];
  assign waddr = {in_i.row_index, in_i.column_index};
  assign laddr = {row_q, kidx};
  assign raddr = {kidx, col_q};
  assign in_i.ready = state_q == sfmm_pkg::StIdle;
  assign in_acc = in_i.valid && in_i.ready;
  assign lwe = in_acc && in_i.op == sfmm_pkg::OpLoadLeft;
  assign rwe = in_acc && in_i.op == sfmm_pkg::OpLoadRight;

  sfmm_ram #(.Width(32), .Depth(sfmm_pkg::Depth)) u_left (
    .clk_i, .we_i(lwe), .waddr_i(waddr), .wdata_i(in_i.element_bits),
    .raddr_i(laddr), .rdata_o(ldata));
  sfmm_ram #(.Width(32), .Depth(sfmm_pkg::Depth)) u_right (
    .clk_i, .we_i(rwe), .waddr_i(waddr), .wdata_i(in_i.element_bits),
    .raddr_i(raddr), .rdata_o(rdata));

  always_comb begin
    state_d = state_q; k_d = k_q; kmax_d = kmax_q;
    sum_d = sum_q; prod_d = prod_q; res_d = res_q; err_d = err_q;
    out_vld = 1'b0;
    case (state_q)
      sfmm_pkg::StIdle: begin
        if (in_acc && in_i.op == sfmm_pkg::OpQuery) begin
          k_d = '0; sum_d = '0;
          kmax_d = (inner_q > 7'(sfmm_pkg::MaxDim)) ? sfmm_pkg::KW'(sfmm_pkg::MaxDim)
                                                   : sfmm_pkg::KW'(inner_q);
          if ({1'b0, in_i.row_index} >= rows_q || {1'b0, in_i.column_index} >= cols_q) begin
            res_d = '0; err_d = 1'b1; state_d = sfmm_pkg::StOut;
          end else begin
            err_d = 1'b0; state_d = sfmm_pkg::StRead;
          end
        end
      end
      sfmm_pkg::StRead: begin
        if (k_q == kmax_q) begin
          res_d = sum_q; state_d = sfmm_pkg::StOut;
        end else state_d = sfmm_pkg::StMul;
      end
      sfmm_pkg::StMul: begin
        prod_d = sfmm_pkg::fmul(ldata, rdata); state_d = sfmm_pkg::StAdd;
      end
      sfmm_pkg::StAdd: begin
        sum_d = sfmm_pkg::fadd(sum_q, prod_q);
        k_d = k_q + 1'b1; state_d = sfmm_pkg::StRead;
      end
      sfmm_pkg::StOut: begin
        out_vld = 1'b1;
        if (out_o.ready) state_d = sfmm_pkg::StIdle;
      end
      default: state_d = sfmm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfmm_pkg::StIdle; k_q <= '0; kmax_q <= '0; err_q <= 1'b0;
    end else begin
      state_q <= state_d; k_q <= k_d; kmax_q <= kmax_d; err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin row_q <= in_i.row_index; col_q <= in_i.column_index; end
    sum_q <= sum_d; prod_q <= prod_d; res_q <= res_d;
  end

  assign out_o.valid = out_vld;
  assign out_o.result_bits = res_q;
  assign out_o.index_error = err_q;

  `ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_o.valid && out_o.index_error, out_o.result_bits == 32'd0)
  `ASSERT_IMP(a_k_bound, clk_i, rst_ni, state_q != sfmm_pkg::StIdle, k_q <= kmax_q)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.result_bits))
  `ASSERT_IMP(a_no_load_busy, clk_i, rst_ni, state_q != sfmm_pkg::StIdle, !lwe && !rwe)
endmodule
`default_nettype wire
